// ===== hw/rtl/lcr_pkg.sv =====
// Shared constants and types for the line clipper.
// Region code bits, register indexes and the per-word control group.
// No dependencies.
`default_nettype none

package lcr_pkg;

  localparam int CFG_IDX_W = 8;

  // Region code bits
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam int NUM_ROUNDS = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 8'd3;

  // Control that travels with each word through the rounds
  typedef struct packed {
    logic vld;   // slot holds a word
    logic done;  // decision already made
    logic acc;   // decision: accepted
  } lcr_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcr_seg_if.sv =====
// Segment input channel: valid/ready plus two endpoints.
// Depends on nothing.
`default_nettype none

interface lcr_seg_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcr_res_if.sv =====
// Result output channel: valid/ready plus accept flag and clipped endpoints.
// Depends on nothing.
`default_nettype none

interface lcr_res_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic accepted;
  logic signed [W-1:0] clip_start_x;
  logic signed [W-1:0] clip_start_y;
  logic signed [W-1:0] clip_end_x;
  logic signed [W-1:0] clip_end_y;

  modport source(output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                 clip_end_y, input ready);
  modport sink(input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
               clip_end_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcr_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on lcr_pkg for the index width.
`default_nettype none

interface lcr_cfg_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic [lcr_pkg::CFG_IDX_W-1:0] index;
  logic signed [W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcr_round.sv =====
// One clipping round: classify, multiply, bit-per-stage divide, move endpoint.
// Depends on lcr_pkg.
`default_nettype none

module lcr_round #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire lcr_pkg::lcr_ctl_t   ctl_in,
  input  wire logic signed [W-1:0] x1_in,
  input  wire logic signed [W-1:0] y1_in,
  input  wire logic signed [W-1:0] x2_in,
  input  wire logic signed [W-1:0] y2_in,
  input  wire logic signed [W-1:0] win_left,
  input  wire logic signed [W-1:0] win_bottom,
  input  wire logic signed [W-1:0] win_right,
  input  wire logic signed [W-1:0] win_top,
  output lcr_pkg::lcr_ctl_t        ctl_out,
  output logic signed [W-1:0]      x1_out,
  output logic signed [W-1:0]      y1_out,
  output logic signed [W-1:0]      x2_out,
  output logic signed [W-1:0]      y2_out
);

  localparam int MW = W + 1;
  localparam int PW = 2 * MW;
  localparam int QW = (PW > 41) ? PW : 41;
  localparam int SW = QW + 2;
  localparam logic [QW-1:0] QLIM = QW'(1) << 40;
  localparam logic signed [SW-1:0] CMAX = $signed((SW'(1) << (W - 1)) - SW'(1));
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  typedef struct packed {
    lcr_pkg::lcr_ctl_t   ctl;
    logic                mv;     // a move happens this round
    logic                sel1;   // move the first endpoint
    logic                horiz;  // horizontal edge: new y is the edge
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] y2;
    logic signed [W-1:0] edgev;
    logic signed [W-1:0] base;
    logic                neg;
    logic                zdiv;
  } side_t;

  function automatic logic [3:0] region(input logic signed [W-1:0] x,
                                        input logic signed [W-1:0] y,
                                        input logic signed [W-1:0] l,
                                        input logic signed [W-1:0] b,
                                        input logic signed [W-1:0] r,
                                        input logic signed [W-1:0] t);
    logic [3:0] c;
    c = '0;
    if (x < l) c = c | lcr_pkg::CODE_LEFT;
    else if (x > r) c = c | lcr_pkg::CODE_RIGHT;
    if (y < b) c = c | lcr_pkg::CODE_BOTTOM;
    else if (y > t) c = c | lcr_pkg::CODE_TOP;
    return c;
  endfunction

  // ---------------- classify stage ----------------
  logic [3:0] c1, c2, co;
  logic signed [MW-1:0] dx, dy, d_top, d_bot, d_rgt, d_lft, a, b, c;
  side_t d_next;

  always_comb begin
    c1 = region(x1_in, y1_in, win_left, win_bottom, win_right, win_top);
    c2 = region(x2_in, y2_in, win_left, win_bottom, win_right, win_top);
    dx    = MW'(x2_in) - MW'(x1_in);
    dy    = MW'(y2_in) - MW'(y1_in);
    d_top = MW'(win_top) - MW'(y1_in);
    d_bot = MW'(win_bottom) - MW'(y1_in);
    d_rgt = MW'(win_right) - MW'(x1_in);
    d_lft = MW'(win_left) - MW'(x1_in);
    co = (c1 != '0) ? c1 : c2;
    d_next.ctl   = ctl_in;
    d_next.mv    = 1'b0;
    d_next.sel1  = (c1 != '0);
    d_next.horiz = 1'b1;
    d_next.x1    = x1_in;
    d_next.y1    = y1_in;
    d_next.x2    = x2_in;
    d_next.y2    = y2_in;
    d_next.edgev = win_top;
    d_next.base  = x1_in;
    a = dx;
    b = d_top;
    c = dy;
    if ((co & lcr_pkg::CODE_TOP) != '0) begin
      d_next.edgev = win_top;
    end else if ((co & lcr_pkg::CODE_BOTTOM) != '0) begin
      b = d_bot;
      d_next.edgev = win_bottom;
    end else if ((co & lcr_pkg::CODE_RIGHT) != '0) begin
      a = dy; b = d_rgt; c = dx;
      d_next.horiz = 1'b0;
      d_next.edgev = win_right;
      d_next.base  = y1_in;
    end else begin
      a = dy; b = d_lft; c = dx;
      d_next.horiz = 1'b0;
      d_next.edgev = win_left;
      d_next.base  = y1_in;
    end
    d_next.neg  = a[MW-1] ^ b[MW-1] ^ c[MW-1];
    d_next.zdiv = (c == '0);
    if (!ctl_in.done) begin
      if (c1 == '0 && c2 == '0) begin
        d_next.ctl.done = 1'b1;
        d_next.ctl.acc  = 1'b1;
      end else if ((c1 & c2) != '0) begin
        d_next.ctl.done = 1'b1;
        d_next.ctl.acc  = 1'b0;
      end else begin
        d_next.mv = 1'b1;
      end
    end
  end

  side_t s_d;
  logic [MW-1:0] ua, ub, uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_d.ctl.vld <= 1'b0;
    end else if (en) begin
      s_d <= d_next;
      ua  <= a[MW-1] ? MW'(-a) : MW'(a);
      ub  <= b[MW-1] ? MW'(-b) : MW'(b);
      uc  <= c[MW-1] ? MW'(-c) : MW'(c);
    end
  end

  // ---------------- multiply, then divide one bit per stage ----------------
  side_t         s_q  [0:PW];
  logic [PW-1:0] pq   [0:PW];
  logic [MW-1:0] rem  [0:PW];
  logic [MW-1:0] dvs  [0:PW];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_q[0].ctl.vld <= 1'b0;
    end else if (en) begin
      s_q[0] <= s_d;
      pq[0]  <= ua * ub;
      rem[0] <= '0;
      dvs[0] <= uc;
    end
  end

  for (genvar k = 0; k < PW; k++) begin : g_div
    logic [MW:0] rsh, diff;
    logic        ge;
    assign rsh  = {rem[k], pq[k][PW-1]};
    assign ge   = (rsh >= {1'b0, dvs[k]});
    assign diff = rsh - {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        s_q[k+1].ctl.vld <= 1'b0;
      end else if (en) begin
        s_q[k+1] <= s_q[k];
        pq[k+1]  <= {pq[k][PW-2:0], ge};
        rem[k+1] <= ge ? diff[MW-1:0] : rsh[MW-1:0];
        dvs[k+1] <= dvs[k];
      end
    end
  end

  // ---------------- clamp, add base, saturate, move ----------------
  side_t sf;
  logic [QW-1:0] qe, qc;
  logic signed [SW-1:0] bse, qs, sum;
  logic signed [W-1:0] nc;

  always_comb begin
    sf  = s_q[PW];
    qe  = QW'(pq[PW]);
    qc  = sf.zdiv ? '0 : ((qe > QLIM) ? QLIM : qe);
    bse = SW'(sf.base);
    qs  = $signed({2'b00, qc});
    sum = sf.neg ? (bse - qs) : (bse + qs);
    if (sum > CMAX) nc = CMAX[W-1:0];
    else if (sum < CMIN) nc = CMIN[W-1:0];
    else nc = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out <= sf.ctl;
      x1_out  <= sf.x1;
      y1_out  <= sf.y1;
      x2_out  <= sf.x2;
      y2_out  <= sf.y2;
      if (sf.mv && sf.sel1) begin
        x1_out <= sf.horiz ? nc : sf.edgev;
        y1_out <= sf.horiz ? sf.edgev : nc;
      end else if (sf.mv) begin
        x2_out <= sf.horiz ? nc : sf.edgev;
        y2_out <= sf.horiz ? sf.edgev : nc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_clip_to_rectangle.sv =====
// Top level of the line clipper: config registers, four clipping rounds,
// final decision and output register. Depends on lcr_pkg, the three channel
// interfaces and lcr_round.
`default_nettype none

// Channel   Dir  Payload                                        Moves
// segment   in   start_x start_y end_x end_y                    one segment per word
// result    out  accepted clip_start_x clip_start_y             one result per word
//                clip_end_x clip_end_y
// cfg       in   index data                                     one register write per word
//
// One segment enters per cycle while result is not stalled. Each of the four
// rounds is a classify stage, a multiply stage, one restoring-divide stage per
// product bit and a move stage, and an output register follows the rounds.
// Synchronous active-high rst empties every stage and loads the window reset
// values. A stall on result freezes the whole pipeline and drops segment.ready;
// cfg is always ready.

module line_clip_to_rectangle #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  lcr_seg_if.sink    segment,
  lcr_res_if.source  result,
  lcr_cfg_if.sink    cfg
);

  localparam int W = COORD_WIDTH;
  localparam int NR = lcr_pkg::NUM_ROUNDS;

  // ---- window registers ----
  logic signed [W-1:0] win_left, win_bottom, win_right, win_top;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= W'(40);
      win_bottom <= W'(40);
      win_right  <= W'(100);
      win_top    <= W'(80);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lcr_pkg::REG_WIN_LEFT:   win_left   <= cfg.data;
        lcr_pkg::REG_WIN_BOTTOM: win_bottom <= cfg.data;
        lcr_pkg::REG_WIN_RIGHT:  win_right  <= cfg.data;
        lcr_pkg::REG_WIN_TOP:    win_top    <= cfg.data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---- pipeline advance: move whenever the output slot is free or taken ----
  logic en;
  assign en = !result.valid || result.ready;
  assign segment.ready = en;

  // ---- round chain ----
  lcr_pkg::lcr_ctl_t   ctl_c [0:NR];
  logic signed [W-1:0] x1_c  [0:NR];
  logic signed [W-1:0] y1_c  [0:NR];
  logic signed [W-1:0] x2_c  [0:NR];
  logic signed [W-1:0] y2_c  [0:NR];

  always_comb begin
    ctl_c[0].vld  = segment.valid;
    ctl_c[0].done = 1'b0;
    ctl_c[0].acc  = 1'b0;
    x1_c[0] = segment.start_x;
    y1_c[0] = segment.start_y;
    x2_c[0] = segment.end_x;
    y2_c[0] = segment.end_y;
  end

  for (genvar r = 0; r < NR; r++) begin : g_round
    lcr_round #(.W(W)) u_round (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .ctl_in     (ctl_c[r]),
      .x1_in      (x1_c[r]),
      .y1_in      (y1_c[r]),
      .x2_in      (x2_c[r]),
      .y2_in      (y2_c[r]),
      .win_left   (win_left),
      .win_bottom (win_bottom),
      .win_right  (win_right),
      .win_top    (win_top),
      .ctl_out    (ctl_c[r+1]),
      .x1_out     (x1_c[r+1]),
      .y1_out     (y1_c[r+1]),
      .x2_out     (x2_c[r+1]),
      .y2_out     (y2_c[r+1])
    );
  end

  // ---- final decision after the move limit ----
  // A word still undecided after four moves is accepted only if both
  // endpoints now sit inside the window.
  logic in1, in2, acc_fin;

  always_comb begin
    in1 = (x1_c[NR] >= win_left) && (x1_c[NR] <= win_right) &&
          (y1_c[NR] >= win_bottom) && (y1_c[NR] <= win_top);
    in2 = (x2_c[NR] >= win_left) && (x2_c[NR] <= win_right) &&
          (y2_c[NR] >= win_bottom) && (y2_c[NR] <= win_top);
    acc_fin = ctl_c[NR].done ? ctl_c[NR].acc : (in1 && in2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid        <= ctl_c[NR].vld;
      result.accepted     <= acc_fin;
      // zero the endpoints of a rejected segment
      result.clip_start_x <= acc_fin ? x1_c[NR] : '0;
      result.clip_start_y <= acc_fin ? y1_c[NR] : '0;
      result.clip_end_x   <= acc_fin ? x2_c[NR] : '0;
      result.clip_end_y   <= acc_fin ? y2_c[NR] : '0;
    end
  end

  // ---- checks ----
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.accepted |->
      result.clip_start_x == '0 && result.clip_start_y == '0 &&
      result.clip_end_x == '0 && result.clip_end_y == '0)
    else $error("rejected word carries nonzero endpoints");

  a_acc_inside: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.accepted |->
      result.clip_start_x >= win_left && result.clip_start_x <= win_right &&
      result.clip_end_y >= win_bottom && result.clip_end_y <= win_top)
    else $error("accepted word lies outside the window");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !segment.ready)
    else $error("segment taken while the output is stalled");

  a_adv: assert property (@(posedge clk) disable iff (rst)
    !result.valid |=> $past(ctl_c[NR].vld) == result.valid)
    else $error("word lost on the way to the output register");

endmodule

`default_nettype wire
